[sv/rmst_pkg.sv]
package rmst_pkg;

    // Table geometry.
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int DATA_W       = 32;
    localparam int POS_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = POS_W + 1;
    localparam int SPAN_W       = CNT_W + 1;
    localparam int LVL_W        = $clog2(LEVELS + 1);
    localparam int MEM_DEPTH    = LEVELS << POS_W;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    // Request codes.
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic app_start;
        logic app_step;
        logic q_start;
        logic q_read_a;
        logic q_read_b;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic q_err;
        logic app_more;
        logic out_free;
    } t_stat;

endpackage

[sv/rmst_ctrl.sv]
module rmst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [rmst_pkg::REQ_W-1:0]  i_req_type,
    input  rmst_pkg::t_stat             i_stat,
    output logic                        o_in_ready,
    output rmst_pkg::t_cmd              o_cmd
);
    import rmst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_APP  = 3'd1;
    localparam logic [2:0] S_QA   = 3'd2;
    localparam logic [2:0] S_QB   = 3'd3;
    localparam logic [2:0] S_QOUT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_req_type)
                        REQ_APPEND: begin
                            // A full table ignores the append.
                            if (!i_stat.full) begin
                                o_cmd.app_start = 1'b1;
                                n_state         = S_APP;
                            end
                        end
                        REQ_QUERY: begin
                            o_cmd.q_start = 1'b1;
                            n_state       = i_stat.q_err ? S_QOUT : S_QA;
                        end
                        REQ_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APP: begin
                if (i_stat.app_more) begin
                    o_cmd.app_step = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_QA: begin
                o_cmd.q_read_a = 1'b1;
                n_state        = S_QB;
            end
            S_QB: begin
                o_cmd.q_read_b = 1'b1;
                n_state        = S_QOUT;
            end
            S_QOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/rmst_dp.sv]
module rmst_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rmst_pkg::t_cmd                      i_cmd,
    input  logic signed [rmst_pkg::DATA_W-1:0]  i_value,
    input  logic [rmst_pkg::POS_W-1:0]          i_query_left,
    input  logic [rmst_pkg::POS_W-1:0]          i_query_right,
    input  logic                                i_out_ready,
    output rmst_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic signed [rmst_pkg::DATA_W-1:0]  o_min_value,
    output logic                                o_range_error
);
    import rmst_pkg::*;

    // Level table: level k lives at address {k, position}.
    logic signed [DATA_W-1:0] r_mem [0:MEM_DEPTH-1];
    logic signed [DATA_W-1:0] r_rdata;

    logic [CNT_W-1:0]         r_count;
    logic [POS_W-1:0]         r_pos;
    logic [LVL_W-1:0]         r_level;
    logic signed [DATA_W-1:0] r_run;
    logic [POS_W-1:0]         r_left;
    logic [POS_W-1:0]         r_right;
    logic [LVL_W-1:0]         r_lg;
    logic                     r_qerr;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_min;
    logic                     r_rerr;

    logic                     mem_we;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_wdata;

    logic [SPAN_W-1:0]        p1;
    logic [SPAN_W-1:0]        span;
    logic [SPAN_W-1:0]        span2;
    logic [SPAN_W-1:0]        start_w;
    logic [SPAN_W-1:0]        start2_w;
    logic signed [DATA_W-1:0] min_v;
    logic [CNT_W-1:0]         q_len;
    logic [LVL_W-1:0]         q_lg;
    logic [CNT_W-1:0]         b_pos_w;
    logic [POS_W-1:0]         cnt_prev;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [POS_W-1:0] pos);
        mem_addr = ADDR_W'({lvl, pos});
    endfunction

    // Append walk: the entry of level k that ends at pos starts at pos+1-2^k.
    assign p1       = SPAN_W'(r_pos) + SPAN_W'(1);
    assign span     = SPAN_W'(1) << r_level;
    assign span2    = span << 1;
    assign start_w  = p1 - span;
    assign start2_w = p1 - span2;
    assign min_v    = (r_rdata < r_run) ? r_rdata : r_run;
    assign cnt_prev = r_count[POS_W-1:0] - POS_W'(1);

    // Query block size from the floor of log2 of the range length.
    assign q_len = CNT_W'(i_query_right) - CNT_W'(i_query_left) + CNT_W'(1);

    always_comb begin
        q_lg = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (q_len[i]) begin
                q_lg = LVL_W'(i);
            end
        end
        if (q_lg > LVL_W'(LEVELS - 1)) begin
            q_lg = LVL_W'(LEVELS - 1);
        end
    end

    assign b_pos_w = CNT_W'(r_right) + CNT_W'(1) - (CNT_W'(1) << r_lg);

    always_comb begin
        o_stat.full     = (r_count == CNT_W'(MAX_ELEMENTS));
        o_stat.q_err    = (i_query_left > i_query_right) || (CNT_W'(i_query_right) >= r_count);
        o_stat.app_more = (r_level < LVL_W'(LEVELS)) && (span <= p1);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // Memory port control.
    always_comb begin
        mem_we    = i_cmd.app_start || i_cmd.app_step;
        mem_re    = i_cmd.app_start || i_cmd.app_step || i_cmd.q_read_a || i_cmd.q_read_b;
        mem_waddr = mem_addr(r_level, start_w[POS_W-1:0]);
        mem_wdata = min_v;
        mem_raddr = mem_addr(r_level, start2_w[POS_W-1:0]);
        if (i_cmd.app_start) begin
            mem_waddr = mem_addr('0, r_count[POS_W-1:0]);
            mem_wdata = i_value;
            mem_raddr = mem_addr('0, cnt_prev);
        end else if (i_cmd.q_read_a) begin
            mem_raddr = mem_addr(r_lg, r_left);
        end else if (i_cmd.q_read_b) begin
            mem_raddr = mem_addr(r_lg, b_pos_w[POS_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_start) begin
            r_pos   <= r_count[POS_W-1:0];
            r_run   <= i_value;
            r_level <= LVL_W'(1);
        end else if (i_cmd.app_step) begin
            r_run   <= min_v;
            r_level <= r_level + LVL_W'(1);
        end else if (i_cmd.q_read_b) begin
            r_run <= r_rdata;
        end
        if (i_cmd.q_start) begin
            r_left  <= i_query_left;
            r_right <= i_query_right;
            r_lg    <= q_lg;
            r_qerr  <= o_stat.q_err;
        end
        if (i_cmd.load_out) begin
            r_min  <= r_qerr ? '0 : min_v;
            r_rerr <= r_qerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.app_start) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_value   = r_min;
    assign o_range_error = r_rerr;

endmodule

[sv/range_minimum_sparse_table.sv]
// Sparse-table range-minimum engine over signed 32-bit words.
// The input channel (i_in_valid / o_in_ready) carries one request word:
// append a value at the next position, query the minimum over
// [i_query_left, i_query_right], or clear the loaded set. The output
// channel (o_out_valid / i_out_ready) carries one word per query only.
// An append writes the base level and then each level above it up to
// floor(log2(position + 1)) in turn: the table has a single write and a
// single read port, and each level above the base uses that port pair.
// A query steps through S_QA, S_QB and S_QOUT to its result register
// (straight to S_QOUT on a range error), because the two overlapping
// blocks are fetched one after the other through the read port.
// A finished result sits in an output register; while the receiver
// stalls, appends and clears still proceed, and a following query waits
// in its last cycle until the register frees up.
// Reset empties the loaded set and drops o_out_valid; the table contents
// are not cleared, since no legal query reads an entry never written.
module range_minimum_sparse_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rmst_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [rmst_pkg::DATA_W-1:0]  i_value,
    input  logic [rmst_pkg::POS_W-1:0]          i_query_left,
    input  logic [rmst_pkg::POS_W-1:0]          i_query_right,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rmst_pkg::DATA_W-1:0]  o_min_value,
    output logic                                o_range_error
);
    import rmst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each request; the datapath owns the table.
    rmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rmst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       (i_value),
        .i_query_left  (i_query_left),
        .i_query_right (i_query_right),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_min_value   (o_min_value),
        .o_range_error (o_range_error)
    );

endmodule

[sv/rmst_checker.sv]
module rmst_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [rmst_pkg::REQ_W-1:0]          i_req_type,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [rmst_pkg::DATA_W-1:0]  o_min_value,
    input logic                                o_range_error
);
    import rmst_pkg::*;

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_min_value) && $stable(o_range_error))
        else $error("stalled result changed");

    // An error result carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_min_value == '0)
        else $error("error result with nonzero value");

    // A query occupies the engine for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_req_type == REQ_QUERY |=> !o_in_ready)
        else $error("ready right after a query");

endmodule

bind range_minimum_sparse_table rmst_checker u_rmst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_req_type    (i_req_type),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_min_value   (o_min_value),
    .o_range_error (o_range_error)
);
